// ===== sv/bvrs_pkg.sv =====
// bvrs_pkg: shared types and constants for the bit vector reduce/scan block
// request and result payload structs, per-word summary struct, opcode enum and fixed field widths
// no dependencies
package bvrs_pkg;

  localparam int WORD_BITS      = 64;
  localparam int VB_BITS        = 7;
  localparam int OUT_COUNT_BITS = 32;
  localparam int ONES_BITS      = $clog2(WORD_BITS + 1);

  localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = '1;

  typedef enum logic [2:0] {
    OP_SUM   = 3'd0,
    OP_ALL   = 3'd1,
    OP_ANY   = 3'd2,
    OP_XOR   = 3'd3,
    OP_XNOR  = 3'd4,
    OP_ASCAN = 3'd5,
    OP_XSCAN = 3'd6,
    OP_NSCAN = 3'd7
  } op_t;

  typedef struct packed {
    op_t                  opcode;
    logic [WORD_BITS-1:0] data_word;
    logic [VB_BITS-1:0]   valid_bits;
    logic                 last_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]      result_word;
    logic [OUT_COUNT_BITS-1:0] result_count;
    logic                      result_last;
  } out_item_t;

  // per-word summary handed from the word logic to the accumulators
  typedef struct packed {
    logic [ONES_BITS-1:0] ones;
    logic                 n_odd;
    logic                 full;
    logic                 nz;
  } word_info_t;

endpackage

// ===== sv/bit_vector_reduce_scan_top.sv =====
// a request is taken into the input register and its result is then loaded into the
// result register, which drives out_data
// throughput: one word per cycle while out_ready does not stall; the popcount and
// log-depth prefix network sit between the input and result registers, with a one-bit
// carry closing the loop; reset (rst_n low, synchronous): both stages empty, counts zero,
// all-ones flag set, scan carry one
module bit_vector_reduce_scan_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bvrs_pkg::out_item_t out_data
);
  import bvrs_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_r;
  logic      out_valid_r;
  out_item_t out_r;

  logic      res_valid;
  out_item_t res;
  logic      out_free;
  logic      adv;

  bvrs_accum #(
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (s1_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // words that make no result move on even while the result reg is full
  assign out_free  = !out_valid_r || out_ready;
  assign adv       = s1_valid_r && (out_free || !res_valid);
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (adv && res_valid) begin
      out_r <= res;
    end
  end

  a_count_only_on_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.result_count == '0) ||
                    (out_r.result_last && out_r.result_word == '0))
    else $error("count reported on a non-sum result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_valid |=> out_valid_r && (out_r == $past(res)))
    else $error("produced result not captured");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_r))
    else $error("stalled word lost from input stage");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && res_valid && !out_free |-> !adv)
    else $error("word advanced into a full result register");

endmodule

// ===== sv/bvrs_word_unit.sv =====
// bvrs_word_unit: combinational per-word logic (valid mask, popcount, prefix scans)
// depends on bvrs_pkg
module bvrs_word_unit (
  input  bvrs_pkg::in_item_t                  item,
  input  logic                                carry_in,
  output logic [bvrs_pkg::WORD_BITS-1:0]      scan_word,
  output logic                                carry_out,
  output bvrs_pkg::word_info_t                info
);
  import bvrs_pkg::*;

  localparam int LEVELS = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONES = '1;

  // element 0 sits in the top bit, so earlier elements are at higher bits
  function automatic logic [WORD_BITS-1:0] prefix_and(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] v;
    v = x;
    for (int lv = 0; lv < LEVELS; lv++) begin
      v = v & ((v >> (1 << lv)) | ~(ONES >> (1 << lv)));
    end
    return v;
  endfunction

  function automatic logic [WORD_BITS-1:0] prefix_xor(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] v;
    v = x;
    for (int lv = 0; lv < LEVELS; lv++) begin
      v = v ^ (v >> (1 << lv));
    end
    return v;
  endfunction

  logic [VB_BITS-1:0]   n;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] d;
  logic [WORD_BITS-1:0] inv_d;

  always_comb begin
    n     = (item.valid_bits > VB_BITS'(WORD_BITS)) ? VB_BITS'(WORD_BITS) : item.valid_bits;
    mask  = ~(ONES >> n);
    d     = item.data_word & mask;
    inv_d = d ^ mask;

    info.ones  = ONES_BITS'($countones(d));
    info.n_odd = n[0];
    info.full  = (d == mask);
    info.nz    = (d != '0);

    unique case (item.opcode)
      OP_ASCAN: begin
        scan_word = carry_in ? (prefix_and(d | ~mask) & mask) : '0;
        carry_out = carry_in & info.full;
      end
      OP_XSCAN: begin
        scan_word = (prefix_xor(d) ^ {WORD_BITS{carry_in}}) & mask;
        carry_out = carry_in ^ (^d);
      end
      OP_NSCAN: begin
        // xnor chain equals xor over inverted bits
        scan_word = (prefix_xor(inv_d) ^ {WORD_BITS{carry_in}}) & mask;
        carry_out = carry_in ^ (^inv_d);
      end
      default: begin
        scan_word = '0;
        carry_out = carry_in;
      end
    endcase
  end

endmodule

// ===== sv/bvrs_accum.sv =====
// bvrs_accum: per-vector accumulators, scan carry and result formation
// depends on bvrs_pkg and bvrs_word_unit
module bvrs_accum #(
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  bvrs_pkg::in_item_t   item,
  output logic                 res_valid,
  output bvrs_pkg::out_item_t  res
);
  import bvrs_pkg::*;

  localparam int EXT_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

  logic [COUNT_BITS-1:0] ones_total_r;
  logic                  all_ones_r;
  logic                  any_one_r;
  logic                  ones_par_r;
  logic                  bits_par_r;
  logic                  scan_carry_r;
  logic                  in_vector_r;

  logic                  carry_in;
  logic                  carry_out;
  logic [WORD_BITS-1:0]  scan_word;
  word_info_t            info;
  logic                  is_scan;
  logic [COUNT_BITS:0]   sum_w;
  logic [COUNT_BITS-1:0] ones_total_nxt;
  logic                  all_ones_nxt;
  logic                  any_one_nxt;
  logic                  ones_par_nxt;
  logic                  bits_par_nxt;
  logic [EXT_BITS-1:0]   ones_ext;
  logic [OUT_COUNT_BITS-1:0] count_out;
  logic                  red_bit;

  // the carry is reloaded at the first word of every vector
  assign carry_in = in_vector_r ? scan_carry_r : (item.opcode != OP_XSCAN);

  bvrs_word_unit u_word (
    .item      (item),
    .carry_in  (carry_in),
    .scan_word (scan_word),
    .carry_out (carry_out),
    .info      (info)
  );

  always_comb begin
    is_scan        = (item.opcode == OP_ASCAN) || (item.opcode == OP_XSCAN) ||
                     (item.opcode == OP_NSCAN);
    sum_w          = {1'b0, ones_total_r} + (COUNT_BITS + 1)'(info.ones);
    ones_total_nxt = sum_w[COUNT_BITS] ? '1 : sum_w[COUNT_BITS-1:0];
    all_ones_nxt   = all_ones_r & info.full;
    any_one_nxt    = any_one_r | info.nz;
    ones_par_nxt   = ones_par_r ^ info.ones[0];
    bits_par_nxt   = bits_par_r ^ info.n_odd;
    ones_ext       = EXT_BITS'(ones_total_nxt);
    count_out      = (ones_ext > EXT_BITS'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                            : ones_ext[OUT_COUNT_BITS-1:0];

    unique case (item.opcode)
      OP_ALL:  red_bit = all_ones_nxt;
      OP_ANY:  red_bit = any_one_nxt;
      OP_XOR:  red_bit = ones_par_nxt;
      OP_XNOR: red_bit = ~(ones_par_nxt ^ bits_par_nxt);
      default: red_bit = 1'b0;
    endcase

    res_valid = is_scan || item.last_word;
    if (is_scan) begin
      res.result_word  = scan_word;
      res.result_count = '0;
    end else begin
      res.result_word  = WORD_BITS'(red_bit);
      res.result_count = (item.opcode == OP_SUM) ? count_out : '0;
    end
    res.result_last = item.last_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_total_r <= '0;
      all_ones_r   <= 1'b1;
      any_one_r    <= 1'b0;
      ones_par_r   <= 1'b0;
      bits_par_r   <= 1'b0;
      scan_carry_r <= 1'b1;
      in_vector_r  <= 1'b0;
    end else if (adv) begin
      scan_carry_r <= is_scan ? carry_out : carry_in;
      if (item.last_word) begin
        ones_total_r <= '0;
        all_ones_r   <= 1'b1;
        any_one_r    <= 1'b0;
        ones_par_r   <= 1'b0;
        bits_par_r   <= 1'b0;
        in_vector_r  <= 1'b0;
      end else begin
        ones_total_r <= ones_total_nxt;
        all_ones_r   <= all_ones_nxt;
        any_one_r    <= any_one_nxt;
        ones_par_r   <= ones_par_nxt;
        bits_par_r   <= bits_par_nxt;
        in_vector_r  <= 1'b1;
      end
    end
  end

endmodule
